// File: hw/rtl/rsb_pkg.sv
package rsb_pkg;

  // Fixed geometry of the binning stores
  localparam int NUM_BINS   = 128;
  localparam int TS_DEPTH   = NUM_BINS + 1;   // tally/space stores carry one end entry
  localparam int TS_AW      = 8;
  localparam int BIN_W      = 7;
  localparam int TALLY_W    = 17;
  localparam int SPACE_W    = 40;
  localparam int POS_W      = 16;
  localparam int MLIS_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Defaults for the top-level parameters
  localparam int MAX_ROWS_DEF    = 65536;
  localparam int COUNT_WIDTH_DEF = 24;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MLIS     = 1'b1;

  // Bin mapping limits and bin numbers
  localparam logic [31:0] LIM_DIRECT = 32'd121;
  localparam logic [31:0] LIM_B122   = 32'd128;
  localparam logic [31:0] LIM_B123   = 32'd256;
  localparam logic [31:0] LIM_B124   = 32'd512;
  localparam logic [BIN_W-1:0] BIN_122   = 7'd122;
  localparam logic [BIN_W-1:0] BIN_123   = 7'd123;
  localparam logic [BIN_W-1:0] BIN_124   = 7'd124;
  localparam logic [BIN_W-1:0] BIN_MERGE = 7'd127;

  // Last entry of the tally/space stores
  localparam logic [TS_AW-1:0] TS_LAST = 8'(NUM_BINS);

  // Commands from controller to datapath
  typedef struct packed {
    logic in_load;
    logic exec_cnt;
    logic exec_plc;
    logic exec_rd;
    logic exec_rd2;
    logic scan_first;
    logic scan_step;
    logic out_load;
    logic err;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              phase;
    logic              last;
    logic              scan_done;
    logic              out_busy;
  } sts_t;

  // Row count to bin number
  function automatic logic [BIN_W-1:0] pick_bin(input logic [31:0] c);
    logic [BIN_W-1:0] b;
    if (c <= LIM_DIRECT) b = c[BIN_W-1:0];
    else if (c <= LIM_B122) b = BIN_122;
    else if (c <= LIM_B123) b = BIN_123;
    else if (c <= LIM_B124) b = BIN_124;
    else b = BIN_MERGE;
    return b;
  endfunction

endpackage

// File: hw/rtl/rsb_ram.sv
module rsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/rsb_ctrl.sv
module rsb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsb_pkg::sts_t sts,
  output rsb_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RD2   = 3'd3;
  localparam logic [2:0] S_SCAN0 = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       err_r, err_nxt;
  logic       legal;

  // request is valid only in its own phase
  assign legal = ((sts.func == rsb_pkg::FUNC_COUNT) && !sts.phase) ||
                 ((sts.func == rsb_pkg::FUNC_PLACE) &&  sts.phase) ||
                 ((sts.func == rsb_pkg::FUNC_READ)  &&  sts.phase);

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.err   = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        err_nxt   = !legal;
        state_nxt = legal ? S_EXEC : S_OUT;
      end
      S_EXEC: begin
        case (sts.func)
          rsb_pkg::FUNC_COUNT: begin
            cmd.exec_cnt = 1'b1;
            state_nxt    = sts.last ? S_SCAN0 : S_OUT;
          end
          rsb_pkg::FUNC_PLACE: begin
            cmd.exec_plc = 1'b1;
            state_nxt    = S_OUT;
          end
          rsb_pkg::FUNC_READ: begin
            cmd.exec_rd = 1'b1;
            state_nxt   = S_RD2;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_RD2: begin
        cmd.exec_rd2 = 1'b1;
        state_nxt    = S_OUT;
      end
      S_SCAN0: begin
        cmd.scan_first = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// File: hw/rtl/rsb_dp.sv
module rsb_dp #(
  parameter int MAX_ROWS    = rsb_pkg::MAX_ROWS_DEF,
  parameter int COUNT_WIDTH = rsb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request payload
  input  logic [rsb_pkg::FUNC_W-1:0]          in_func,
  input  logic [COUNT_WIDTH-1:0]              in_row_count,
  input  logic [rsb_pkg::BIN_W-1:0]           in_bin_select,
  // controller link
  input  rsb_pkg::cmd_t                       cmd,
  output rsb_pkg::sts_t                       sts,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_status,
  output logic [rsb_pkg::BIN_W-1:0]           out_bin,
  output logic [rsb_pkg::POS_W-1:0]           out_position,
  output logic [rsb_pkg::POS_W-1:0]           out_row,
  output logic [rsb_pkg::SPACE_W-1:0]         out_offset,
  output logic [rsb_pkg::SPACE_W-1:0]         out_total_alloc,
  output logic [rsb_pkg::SPACE_W-1:0]         out_total_full,
  output logic [rsb_pkg::TALLY_W-1:0]         out_bin_first_row,
  output logic [rsb_pkg::TALLY_W-1:0]         out_bin_rows,
  output logic [rsb_pkg::SPACE_W-1:0]         out_bin_first_offset
);

  localparam int TW = rsb_pkg::TALLY_W;
  localparam int SW = rsb_pkg::SPACE_W;
  localparam int BW = rsb_pkg::BIN_W;
  localparam int AW = rsb_pkg::TS_AW;
  localparam int TALLY_MAX = (1 << TW) - 1;
  localparam logic [TW-1:0] ROWS_CAP = TW'((MAX_ROWS > TALLY_MAX) ? TALLY_MAX : MAX_ROWS);

  // configuration registers
  logic [TW-1:0]                 num_rows_r;
  logic [rsb_pkg::MLIS_W-1:0]    mlis_r;

  // latched request
  logic [rsb_pkg::FUNC_W-1:0]    func_r;
  logic [COUNT_WIDTH-1:0]        cnt_r;
  logic [BW-1:0]                 sel_r;

  // run state
  logic                          phase_r;
  logic [TW-1:0]                 rows_seen_r;
  logic [SW-1:0]                 full_sum_r;
  logic [rsb_pkg::TS_DEPTH-1:0]  vld_ts_r;
  logic [rsb_pkg::NUM_BINS-1:0]  vld_pl_r;
  logic                          vts_q_r;
  logic                          vpl_q_r;

  // scan
  logic [AW-1:0]                 scan_idx_r;
  logic [TW-1:0]                 acc_t_r;
  logic [SW-1:0]                 acc_s_r;

  // pending result
  logic [BW-1:0]                 res_bin_r;
  logic [rsb_pkg::POS_W-1:0]     res_pos_r;
  logic [rsb_pkg::POS_W-1:0]     res_row_r;
  logic [SW-1:0]                 res_offset_r;
  logic [SW-1:0]                 res_alloc_r;
  logic [SW-1:0]                 res_full_r;
  logic [TW-1:0]                 res_first_row_r;
  logic [TW-1:0]                 res_rows_r;
  logic [SW-1:0]                 res_first_off_r;

  // output register
  logic                          out_valid_r;
  logic                          out_status_r;
  logic [BW-1:0]                 out_bin_r;
  logic [rsb_pkg::POS_W-1:0]     out_position_r;
  logic [rsb_pkg::POS_W-1:0]     out_row_r;
  logic [SW-1:0]                 out_offset_r;
  logic [SW-1:0]                 out_total_alloc_r;
  logic [SW-1:0]                 out_total_full_r;
  logic [TW-1:0]                 out_bin_first_row_r;
  logic [TW-1:0]                 out_bin_rows_r;
  logic [SW-1:0]                 out_bin_first_offset_r;

  // combinational
  logic [BW-1:0]                 bin_w;
  logic [SW-1:0]                 sp_w;
  logic [TW-1:0]                 n_eff;
  logic                          last_w;
  logic                          clear_w;
  logic [AW-1:0]                 ts_raddr;
  logic [AW-1:0]                 ts_waddr;
  logic                          tally_we;
  logic                          space_we;
  logic [TW-1:0]                 tally_wdata;
  logic [SW-1:0]                 space_wdata;
  logic [TW-1:0]                 tally_rdata;
  logic [SW-1:0]                 space_rdata;
  logic [TW-1:0]                 placed_rdata;
  logic [TW-1:0]                 tally_q;
  logic [SW-1:0]                 space_q;
  logic [TW-1:0]                 placed_q;
  logic [TW-1:0]                 pos_w;

  // bin and space of the latched row
  assign bin_w = rsb_pkg::pick_bin(32'(cnt_r));
  assign sp_w  = (bin_w == rsb_pkg::BIN_MERGE) ? SW'(mlis_r) : SW'(cnt_r);

  // effective row count of a run
  always_comb begin
    if (num_rows_r == '0) n_eff = TW'(1);
    else if (num_rows_r > ROWS_CAP) n_eff = ROWS_CAP;
    else n_eff = num_rows_r;
  end

  assign last_w  = ({1'b0, rows_seen_r} + (TW+1)'(1)) >= {1'b0, n_eff};
  assign clear_w = cmd.exec_plc && last_w;

  // store read data, masked where never written since the last clear
  assign tally_q  = vts_q_r ? tally_rdata  : '0;
  assign space_q  = vts_q_r ? space_rdata  : '0;
  assign placed_q = vpl_q_r ? placed_rdata : '0;
  assign pos_w    = tally_q + placed_q;

  // read address of tally/space stores
  always_comb begin
    if (cmd.scan_first) ts_raddr = '0;
    else if (cmd.scan_step) ts_raddr = (scan_idx_r == rsb_pkg::TS_LAST) ? '0 : scan_idx_r + AW'(1);
    else if (cmd.exec_rd) ts_raddr = {1'b0, sel_r} + AW'(1);
    else if (func_r == rsb_pkg::FUNC_READ) ts_raddr = {1'b0, sel_r};
    else ts_raddr = {1'b0, bin_w};
  end

  // write side of tally/space stores
  assign tally_we    = cmd.exec_cnt || cmd.scan_step;
  assign space_we    = cmd.exec_cnt || cmd.exec_plc || cmd.scan_step;
  assign ts_waddr    = cmd.scan_step ? scan_idx_r : {1'b0, bin_w};
  assign tally_wdata = cmd.scan_step ? acc_t_r : tally_q + TW'(1);
  assign space_wdata = cmd.scan_step ? acc_s_r : space_q + sp_w;

  rsb_ram #(.WIDTH(TW), .DEPTH(rsb_pkg::TS_DEPTH)) u_tally (
    .clk   (clk),
    .we    (tally_we),
    .waddr (ts_waddr),
    .wdata (tally_wdata),
    .raddr (ts_raddr),
    .rdata (tally_rdata)
  );

  rsb_ram #(.WIDTH(SW), .DEPTH(rsb_pkg::TS_DEPTH)) u_space (
    .clk   (clk),
    .we    (space_we),
    .waddr (ts_waddr),
    .wdata (space_wdata),
    .raddr (ts_raddr),
    .rdata (space_rdata)
  );

  rsb_ram #(.WIDTH(TW), .DEPTH(rsb_pkg::NUM_BINS)) u_placed (
    .clk   (clk),
    .we    (cmd.exec_plc),
    .waddr (bin_w),
    .wdata (placed_q + TW'(1)),
    .raddr (bin_w),
    .rdata (placed_rdata)
  );

  // control state: configuration, phase, valid bits, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= TW'(1);
      mlis_r      <= rsb_pkg::MLIS_W'(256);
      phase_r     <= 1'b0;
      rows_seen_r <= '0;
      full_sum_r  <= '0;
      vld_ts_r    <= '0;
      vld_pl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rsb_pkg::REG_NUM_ROWS: num_rows_r <= cfg_data;
          rsb_pkg::REG_MLIS:     mlis_r     <= cfg_data[rsb_pkg::MLIS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec_cnt) begin
        full_sum_r <= full_sum_r + SW'(cnt_r);
        if (last_w) begin
          phase_r     <= 1'b1;
          rows_seen_r <= '0;
        end else begin
          rows_seen_r <= rows_seen_r + TW'(1);
        end
      end
      if (cmd.exec_plc) begin
        rows_seen_r <= last_w ? '0 : rows_seen_r + TW'(1);
      end
      // valid bits: clear at end of placement overrides the writes
      if (clear_w) begin
        phase_r    <= 1'b0;
        full_sum_r <= '0;
        vld_ts_r   <= '0;
        vld_pl_r   <= '0;
      end else begin
        if (tally_we || space_we) vld_ts_r[ts_waddr] <= 1'b1;
        if (cmd.exec_plc) vld_pl_r[bin_w] <= 1'b1;
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload: request latch, scan accumulators, result and output registers
  always_ff @(posedge clk) begin
    vts_q_r <= vld_ts_r[ts_raddr];
    vpl_q_r <= vld_pl_r[bin_w];
    if (cmd.in_load) begin
      func_r          <= in_func;
      cnt_r           <= in_row_count;
      sel_r           <= in_bin_select;
      res_bin_r       <= '0;
      res_pos_r       <= '0;
      res_row_r       <= '0;
      res_offset_r    <= '0;
      res_alloc_r     <= '0;
      res_full_r      <= '0;
      res_first_row_r <= '0;
      res_rows_r      <= '0;
      res_first_off_r <= '0;
    end
    if (cmd.exec_cnt) begin
      res_bin_r <= bin_w;
      res_row_r <= rows_seen_r[rsb_pkg::POS_W-1:0];
      if (last_w) res_full_r <= full_sum_r + SW'(cnt_r);
    end
    if (cmd.exec_plc) begin
      res_bin_r    <= bin_w;
      res_pos_r    <= pos_w[rsb_pkg::POS_W-1:0];
      res_row_r    <= rows_seen_r[rsb_pkg::POS_W-1:0];
      res_offset_r <= space_q;
    end
    if (cmd.exec_rd) begin
      res_bin_r       <= sel_r;
      res_first_row_r <= tally_q;
      res_first_off_r <= space_q;
    end
    if (cmd.exec_rd2) begin
      res_rows_r <= tally_q - res_first_row_r;
    end
    // exclusive scan, one entry per cycle
    if (cmd.scan_first) begin
      scan_idx_r <= '0;
      acc_t_r    <= '0;
      acc_s_r    <= '0;
    end
    if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + AW'(1);
      acc_t_r    <= acc_t_r + tally_q;
      acc_s_r    <= acc_s_r + space_q;
      if (scan_idx_r == rsb_pkg::TS_LAST) res_alloc_r <= acc_s_r;
    end
    if (cmd.out_load) begin
      out_status_r           <= cmd.err;
      out_bin_r              <= res_bin_r;
      out_position_r         <= res_pos_r;
      out_row_r              <= res_row_r;
      out_offset_r           <= res_offset_r;
      out_total_alloc_r      <= res_alloc_r;
      out_total_full_r       <= res_full_r;
      out_bin_first_row_r    <= res_first_row_r;
      out_bin_rows_r         <= res_rows_r;
      out_bin_first_offset_r <= res_first_off_r;
    end
  end

  // status to controller
  assign sts.func      = func_r;
  assign sts.phase     = phase_r;
  assign sts.last      = last_w;
  assign sts.scan_done = (scan_idx_r == rsb_pkg::TS_LAST);
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_bin              = out_bin_r;
  assign out_position         = out_position_r;
  assign out_row              = out_row_r;
  assign out_offset           = out_offset_r;
  assign out_total_alloc      = out_total_alloc_r;
  assign out_total_full       = out_total_full_r;
  assign out_bin_first_row    = out_bin_first_row_r;
  assign out_bin_rows         = out_bin_rows_r;
  assign out_bin_first_offset = out_bin_first_offset_r;

endmodule

// File: hw/rtl/row_size_binning_counting_sort_top.sv
// Channel   Ports                                    Moves
// -------   --------------------------------------   -----------------------------------
// in        in_valid/in_ready, in_func, in_row_count  one request: count, place or read
//           in_bin_select
// out       out_valid/out_ready, out_status .. fields one result per request
// cfg       cfg_we, cfg_index, cfg_data               register write, no wait
//
// Count and place requests pass through latch, store read, update and result load;
// bin reads add a second store read, as the two tally entries share one store read port.
// The last count request adds an exclusive scan over the 129 entries.
// Synchronous reset clears control state; stores read as zero through valid bits, no sweep.
// A stalled result holds in the output register; the next request is taken once it is loaded.
module row_size_binning_counting_sort_top #(
  parameter int MAX_ROWS    = rsb_pkg::MAX_ROWS_DEF,
  parameter int COUNT_WIDTH = rsb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rsb_pkg::FUNC_W-1:0]      in_func,
  input  logic [COUNT_WIDTH-1:0]          in_row_count,
  input  logic [rsb_pkg::BIN_W-1:0]       in_bin_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic [rsb_pkg::BIN_W-1:0]       out_bin,
  output logic [rsb_pkg::POS_W-1:0]       out_position,
  output logic [rsb_pkg::POS_W-1:0]       out_row,
  output logic [rsb_pkg::SPACE_W-1:0]     out_offset,
  output logic [rsb_pkg::SPACE_W-1:0]     out_total_alloc,
  output logic [rsb_pkg::SPACE_W-1:0]     out_total_full,
  output logic [rsb_pkg::TALLY_W-1:0]     out_bin_first_row,
  output logic [rsb_pkg::TALLY_W-1:0]     out_bin_rows,
  output logic [rsb_pkg::SPACE_W-1:0]     out_bin_first_offset
);

  rsb_pkg::cmd_t cmd;
  rsb_pkg::sts_t sts;

  // sequencer
  rsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, scan and result registers
  rsb_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_func              (in_func),
    .in_row_count         (in_row_count),
    .in_bin_select        (in_bin_select),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_bin              (out_bin),
    .out_position         (out_position),
    .out_row              (out_row),
    .out_offset           (out_offset),
    .out_total_alloc      (out_total_alloc),
    .out_total_full       (out_total_full),
    .out_bin_first_row    (out_bin_first_row),
    .out_bin_rows         (out_bin_rows),
    .out_bin_first_offset (out_bin_first_offset)
  );

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CW             = COUNT_WIDTH_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1800;

  // One result as the block reports it
  typedef struct packed {
    logic               status;
    logic [BIN_W-1:0]   bin;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   row;
    logic [SPACE_W-1:0] offset;
    logic [SPACE_W-1:0] total_alloc;
    logic [SPACE_W-1:0] total_full;
    logic [TALLY_W-1:0] first_row;
    logic [TALLY_W-1:0] bin_rows;
    logic [SPACE_W-1:0] first_offset;
  } bin_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func;
  logic [CW-1:0]         in_row_count;
  logic [BIN_W-1:0]      in_bin_select;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_status;
  logic [BIN_W-1:0]      out_bin;
  logic [POS_W-1:0]      out_position;
  logic [POS_W-1:0]      out_row;
  logic [SPACE_W-1:0]    out_offset;
  logic [SPACE_W-1:0]    out_total_alloc;
  logic [SPACE_W-1:0]    out_total_full;
  logic [TALLY_W-1:0]    out_bin_first_row;
  logic [TALLY_W-1:0]    out_bin_rows;
  logic [SPACE_W-1:0]    out_bin_first_offset;

  // Predictor state: tallies and space sums, turned into start positions by the scan
  logic [TALLY_W-1:0] tally_q  [0:NUM_BINS];
  logic [SPACE_W-1:0] space_q  [0:NUM_BINS];
  logic [TALLY_W-1:0] placed_q [0:NUM_BINS-1];
  logic               place_phase;
  int unsigned        row_idx;
  logic [SPACE_W-1:0] count_total;
  logic [TALLY_W-1:0] num_rows_reg;
  logic [MLIS_W-1:0]  merge_size_reg;

  bin_reply_t expected_replies[$];

  // Traffic shaping knobs
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_ask  = 1'b0;

  int errors        = 0;
  int n_checked     = 0;
  int n_count_ok    = 0;
  int n_place_ok    = 0;
  int n_read_ok     = 0;
  int n_rejected    = 0;
  int n_cfg_writes  = 0;
  int stall_cycles  = 0;

  row_size_binning_counting_sort_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_row_count         (in_row_count),
    .in_bin_select        (in_bin_select),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_bin              (out_bin),
    .out_position         (out_position),
    .out_row              (out_row),
    .out_offset           (out_offset),
    .out_total_alloc      (out_total_alloc),
    .out_total_full       (out_total_full),
    .out_bin_first_row    (out_bin_first_row),
    .out_bin_rows         (out_bin_rows),
    .out_bin_first_offset (out_bin_first_offset)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_bins();
    for (int i = 0; i <= NUM_BINS; i++) begin
      tally_q[TS_AW'(i)] = '0;
      space_q[TS_AW'(i)] = '0;
    end
    for (int i = 0; i < NUM_BINS; i++) placed_q[BIN_W'(i)] = '0;
    place_phase = 1'b0;
    row_idx     = 0;
    count_total = '0;
  endfunction

  function automatic logic [BIN_W-1:0] bin_of_count(input logic [CW-1:0] c);
    logic [BIN_W-1:0] b;
    logic [31:0]      cw;
    cw = 32'(c);
    b = BIN_MERGE;
    if (cw <= LIM_DIRECT) b = c[BIN_W-1:0];
    else if (cw <= LIM_B122) b = BIN_122;
    else if (cw <= LIM_B123) b = BIN_123;
    else if (cw <= LIM_B124) b = BIN_124;
    return b;
  endfunction

  // Merge bin reserves a fixed size per row, others reserve the count itself
  function automatic logic [SPACE_W-1:0] row_space(input logic [BIN_W-1:0] b,
                                                  input logic [CW-1:0] c);
    if (b == BIN_MERGE) return SPACE_W'(merge_size_reg);
    return SPACE_W'(c);
  endfunction

  // Rows per run after clamping the register to 1..MAX_ROWS
  function automatic int unsigned rows_per_run();
    int unsigned n;
    n = 32'(num_rows_reg);
    if (n == 0) n = 1;
    if (n > MAX_ROWS_DEF) n = MAX_ROWS_DEF;
    return n;
  endfunction

  // Exclusive scan over all tally and space entries, end entry included
  function automatic void prefix_scan();
    logic [TALLY_W-1:0] acc_rows, t;
    logic [SPACE_W-1:0] acc_space, s;
    acc_rows  = '0;
    acc_space = '0;
    for (int i = 0; i <= NUM_BINS; i++) begin
      t                  = tally_q[TS_AW'(i)];
      s                  = space_q[TS_AW'(i)];
      tally_q[TS_AW'(i)] = acc_rows;
      space_q[TS_AW'(i)] = acc_space;
      acc_rows           = acc_rows + t;
      acc_space          = acc_space + s;
    end
  endfunction

  function automatic bin_reply_t predict_reply(input logic [FUNC_W-1:0] f,
                                               input logic [CW-1:0] c,
                                               input logic [BIN_W-1:0] sel);
    bin_reply_t  r;
    logic [BIN_W-1:0] b;
    logic [TS_AW-1:0] bi;
    logic [TS_AW-1:0] si;
    logic [31:0] pos;
    int unsigned n;
    r = '0;
    n = rows_per_run();
    b = bin_of_count(c);
    bi = TS_AW'(b);
    si = TS_AW'(sel);
    if (f == FUNC_COUNT && !place_phase) begin
      tally_q[bi] = tally_q[bi] + TALLY_W'(1);
      space_q[bi] = space_q[bi] + row_space(b, c);
      count_total = count_total + SPACE_W'(c);
      r.bin = b;
      r.row = row_idx[POS_W-1:0];
      if (row_idx + 1 >= n) begin
        prefix_scan();
        r.total_alloc = space_q[NUM_BINS];
        r.total_full  = count_total;
        place_phase   = 1'b1;
        row_idx       = 0;
      end else begin
        row_idx++;
      end
    end else if (f == FUNC_PLACE && place_phase) begin
      pos         = 32'(tally_q[bi]) + 32'(placed_q[b]);
      r.bin       = b;
      r.position  = pos[POS_W-1:0];
      r.row       = row_idx[POS_W-1:0];
      r.offset    = space_q[bi];
      space_q[bi] = space_q[bi] + row_space(b, c);
      placed_q[b] = placed_q[b] + TALLY_W'(1);
      if (row_idx + 1 >= n) clear_bins();
      else row_idx++;
    end else if (f == FUNC_READ && place_phase) begin
      r.bin          = sel;
      r.first_row    = tally_q[si];
      r.bin_rows     = tally_q[si + TS_AW'(1)] - tally_q[si];
      r.first_offset = space_q[si];
    end else begin
      r.status = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : reply_check
    bin_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        n_checked++;
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("bin", 64'(want.bin), 64'(out_bin));
        check_field("position", 64'(want.position), 64'(out_position));
        check_field("row", 64'(want.row), 64'(out_row));
        check_field("offset", 64'(want.offset), 64'(out_offset));
        check_field("total_alloc", 64'(want.total_alloc), 64'(out_total_alloc));
        check_field("total_full", 64'(want.total_full), 64'(out_total_full));
        check_field("bin_first_row", 64'(want.first_row), 64'(out_bin_first_row));
        check_field("bin_rows", 64'(want.bin_rows), 64'(out_bin_rows));
        check_field("bin_first_offset", 64'(want.first_offset),
                    64'(out_bin_first_offset));
      end
    end
  end

  // Receiver: random stalls, steady mode, or one long hold on request
  initial begin : rx_side
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_steady) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 35);
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no request or result moved for %0d cycles", $time,
               stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one request; valid stays high after acceptance until the next call
  // or an idle wait lowers it
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [CW-1:0] c,
                          input logic [BIN_W-1:0] sel);
    bin_reply_t r;
    if (!tx_steady) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_row_count  <= c;
    in_bin_select <= sel;
    do @(posedge clk); while (!in_ready);
    r = predict_reply(f, c, sel);
    expected_replies.push_back(r);
    if (r.status) n_rejected++;
    else if (f == FUNC_COUNT) n_count_ok++;
    else if (f == FUNC_PLACE) n_place_ok++;
    else n_read_ok++;
  endtask

  // Sender pause until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_NUM_ROWS) num_rows_reg = data;
    else merge_size_reg = data[MLIS_W-1:0];
    n_cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small counts, spread over every bin range, some full width
  function automatic logic [CW-1:0] rand_count();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return CW'($urandom_range(121));
    if (p < 62) return CW'($urandom_range(128, 122));
    if (p < 72) return CW'($urandom_range(256, 129));
    if (p < 82) return CW'($urandom_range(512, 257));
    if (p < 92) return CW'($urandom_range(4096, 513));
    return CW'($urandom);
  endfunction

  function automatic logic [BIN_W-1:0] rand_bin();
    return BIN_W'($urandom_range(NUM_BINS - 1));
  endfunction

  // One full binning run: count phase, then place phase, with reads and
  // out-of-phase noise mixed in; sometimes the row limit is lowered mid-run
  task automatic run_binning(input int rows, input logic [CFG_DATA_W-1:0] merge_size);
    int i;
    int cut;
    wait_idle();
    write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_MLIS, merge_size);
    cut = (rows > 4 && $urandom_range(9) == 0) ? $urandom_range(rows - 2, 1) : -1;
    i = 0;
    while (!place_phase) begin
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(2))
          0: send_req(FUNC_PLACE, rand_count(), rand_bin());
          1: send_req(FUNC_READ, rand_count(), rand_bin());
          default: send_req(FUNC_UNUSED, rand_count(), rand_bin());
        endcase
      end
      if (i == cut) begin
        wait_idle();
        write_reg(REG_NUM_ROWS, CFG_DATA_W'($urandom_range(i, 1)));
      end
      send_req(FUNC_COUNT, rand_count(), rand_bin());
      i++;
    end
    while (place_phase) begin
      if ($urandom_range(99) < 15) send_req(FUNC_READ, rand_count(), rand_bin());
      if ($urandom_range(99) < 6) begin
        if ($urandom_range(1)) send_req(FUNC_COUNT, rand_count(), rand_bin());
        else send_req(FUNC_UNUSED, rand_count(), rand_bin());
      end
      send_req(FUNC_PLACE, rand_count(), rand_bin());
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_merge_size();
    int unsigned p;
    logic [MLIS_W-1:0] m;
    p = $urandom_range(9);
    if (p == 0) m = 16'd1;
    else if (p == 1) m = 16'hFFFF;
    else m = MLIS_W'($urandom_range(65535, 1));
    return {1'($urandom_range(1)), m};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bin boundaries, every request kind, out-of-phase requests, offset advance
  task automatic test_directed();
    logic [CW-1:0] boundary_counts [0:9];
    boundary_counts = '{24'd0, 24'd121, 24'd122, 24'd128, 24'd129, 24'd256,
                        24'd257, 24'd512, 24'd513, 24'hFFFFFF};
    // nothing counted yet: place, read and the unused code are rejected
    send_req(FUNC_PLACE, 24'd5, 7'd0);
    send_req(FUNC_READ, 24'd0, 7'd3);
    send_req(FUNC_UNUSED, 24'hFFFFFF, 7'h7F);
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'd10);
    write_reg(REG_MLIS, 17'h1FFFF);
    for (int i = 0; i < 10; i++) send_req(FUNC_COUNT, boundary_counts[4'(i)], 7'd0);
    // place phase: count and unused rejected, reads at both ends
    send_req(FUNC_COUNT, 24'd1, 7'd0);
    send_req(FUNC_UNUSED, 24'd0, 7'd0);
    send_req(FUNC_READ, 24'd0, 7'd0);
    send_req(FUNC_READ, 24'd0, BIN_MERGE);
    for (int i = 9; i >= 0; i--) begin
      send_req(FUNC_PLACE, boundary_counts[4'(i)], 7'd0);
      if (i == 9) send_req(FUNC_READ, 24'd0, BIN_MERGE);
    end
    // stores cleared after the last placement
    send_req(FUNC_READ, 24'd0, BIN_122);
  endtask

  // Row limit of zero, above the maximum, at the maximum, lowered mid-run
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'd0);
    write_reg(REG_MLIS, 17'd1);
    send_req(FUNC_COUNT, 24'd600, 7'd0);
    send_req(FUNC_READ, 24'd0, BIN_MERGE);
    send_req(FUNC_PLACE, 24'd700, 7'd0);
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'h1FFFF);
    for (int i = 0; i < 20; i++) send_req(FUNC_COUNT, rand_count(), rand_bin());
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'h10000);
    for (int i = 0; i < 10; i++) send_req(FUNC_COUNT, rand_count(), rand_bin());
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'd2);
    send_req(FUNC_COUNT, rand_count(), rand_bin());
    send_req(FUNC_READ, 24'd0, 7'd0);
    send_req(FUNC_READ, 24'd0, BIN_MERGE);
    while (place_phase) send_req(FUNC_PLACE, rand_count(), rand_bin());
  endtask

  // Receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_NUM_ROWS, 17'd60);
    write_reg(REG_MLIS, rand_merge_size());
    tx_steady = 1'b1;
    hold_ask  = 1'b1;
    for (int i = 0; i < 60; i++) send_req(FUNC_COUNT, rand_count(), rand_bin());
    tx_steady = 1'b0;
    wait_idle();
    while (place_phase) begin
      if ($urandom_range(99) < 15) send_req(FUNC_READ, 24'd0, rand_bin());
      send_req(FUNC_PLACE, rand_count(), rand_bin());
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_binning(80, rand_merge_size());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_runs();
    int p;
    int rows;
    while (n_count_ok + n_place_ok + n_read_ok < RANDOM_ITEMS) begin
      p = $urandom_range(99);
      if (p < 80) rows = $urandom_range(24, 1);
      else if (p < 95) rows = $urandom_range(120, 25);
      else rows = $urandom_range(400, 200);
      run_binning(rows, rand_merge_size());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_NUM_ROWS;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_func       = FUNC_COUNT;
    in_row_count  = '0;
    in_bin_select = '0;
    num_rows_reg   = 17'd1;
    merge_size_reg = 16'd256;
    clear_bins();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_backpressure();
    test_steady_stream();
    test_random_runs();

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_replies.size());
      errors++;
    end
    $display("Run covered %0d count, %0d place and %0d bin-read requests, %0d rejected,",
             n_count_ok, n_place_ok, n_read_ok, n_rejected);
    $display("with %0d register writes and %0d results compared field by field.",
             n_cfg_writes, n_checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
